// ----- hw/rtl/fbpa_pkg.sv -----
// ============================================================================
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// Field widths, register codes, reset values, queue entry formats and the
// state types of the front and back sequencers.
// ============================================================================
`default_nettype none

package fbpa_pkg;

  localparam int ADDR_W    = 32;  // byte address width
  localparam int BYTES_W   = 16;  // block_bytes register width
  localparam int CNT_W     = 11;  // block counts and block indexes
  localparam int SIZE_W    = 17;  // rounded block size, up to 65535 + 63
  localparam int PROD_W    = CNT_W + SIZE_W;
  localparam int DIV_STEPS = ADDR_W;
  localparam int REG_IDX_W = 2;

  // Upper bound of MAX_BLOCKS is 2047, the largest count that CNT_W bits hold.
  localparam int MAX_BLOCKS_DEF  = 1024;
  localparam int ALIGN_MASK_DEF  = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [REG_IDX_W-1:0] REG_POOL_BASE   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_TOTAL = REG_IDX_W'(2);

  localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = ADDR_W'(0);
  localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = BYTES_W'(8);
  localparam logic [CNT_W-1:0]   RST_BLOCK_TOTAL = CNT_W'(16);

  typedef enum logic {
    OP_GET     = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_MEMORY   = 2'd1,
    ST_NOT_A_BLOCK = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;   // rounded block size
    logic [CNT_W-1:0]  total;  // effective block count
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quot;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    op_t              op;
    logic             ok;   // release address names a block of the pool
    logic [CNT_W-1:0] idx;  // block index of a release
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] granted;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
  } res_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOK,
    B_MUL,
    B_PUSH
  } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fbpa_fifo.sv -----
// ============================================================================
// fbpa_fifo: small synchronous queue
// Register-based queue of DEPTH entries (DEPTH >= 2) with full/empty flags.
// ============================================================================
`default_nettype none

module fbpa_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = fbpa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire T     din,
  output logic      full,
  input  wire logic pop,
  output T          dout,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_div.sv -----
// ============================================================================
// fbpa_div: iterative restoring divider
// Divides a 32-bit offset by the block size, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module fbpa_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fbpa_pkg::div_req_t req,
  output fbpa_pkg::div_rsp_t      rsp
);

  localparam int AW = fbpa_pkg::ADDR_W;
  localparam int SW = fbpa_pkg::SIZE_W;
  localparam int NW = $clog2(fbpa_pkg::DIV_STEPS);

  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] cnt_r;
  logic [AW-1:0] quot_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] div_r;
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          ge;

  // shift in the next dividend bit and try to subtract
  assign trial = {rem_r, quot_r[AW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NW'(1);
        if (cnt_r == NW'(fbpa_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      rem_r  <= '0;
      div_r  <= req.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[AW-2:0], ge};
      rem_r  <= ge ? diff[SW-1:0] : trial[SW-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_front.sv -----
// ============================================================================
// fbpa_front: request intake and address classification
// Takes one request, turns a release address into a block index and a
// validity flag, and hands a command to the back end.
// ============================================================================
`default_nettype none

module fbpa_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_operation,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]   in_release_address,
  input  wire fbpa_pkg::cfg_t                cfg,
  output logic                               cmd_push,
  output fbpa_pkg::cmd_t                     cmd,
  input  wire logic                          cmd_full
);

  localparam int CW = fbpa_pkg::CNT_W;
  localparam int AW = fbpa_pkg::ADDR_W;

  fbpa_pkg::front_state_t state_r;
  fbpa_pkg::front_state_t state_nxt;
  fbpa_pkg::op_t          op_r;
  logic                   ok_r;
  logic [CW-1:0]          idx_r;
  logic                   accept;
  fbpa_pkg::div_req_t     div_req;
  fbpa_pkg::div_rsp_t     div_rsp;

  assign in_full = (state_r != fbpa_pkg::F_IDLE);
  assign accept  = in_push && !in_full;

  assign div_req.start    = accept && (fbpa_pkg::op_t'(in_operation) == fbpa_pkg::OP_RELEASE);
  assign div_req.dividend = in_release_address - cfg.base;
  assign div_req.divisor  = cfg.size;

  fbpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbpa_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_push  = 1'b0;
    case (state_r)
      fbpa_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = div_req.start ? fbpa_pkg::F_DIV : fbpa_pkg::F_PUSH;
        end
      end
      fbpa_pkg::F_DIV: begin
        if (div_rsp.done) begin
          state_nxt = fbpa_pkg::F_PUSH;
        end
      end
      fbpa_pkg::F_PUSH: begin
        if (!cmd_full) begin
          cmd_push  = 1'b1;
          state_nxt = fbpa_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = fbpa_pkg::F_IDLE;
      end
    endcase
  end

  // in range means quotient below the block count; on boundary means no rest
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= fbpa_pkg::op_t'(in_operation);
      ok_r  <= 1'b0;
      idx_r <= '0;
    end else if (state_r == fbpa_pkg::F_DIV && div_rsp.done) begin
      ok_r  <= (cfg.size != '0) && (div_rsp.rem == '0) && (div_rsp.quot < AW'(cfg.total));
      idx_r <= div_rsp.quot[CW-1:0];
    end
  end

  assign cmd.op  = op_r;
  assign cmd.ok  = ok_r;
  assign cmd.idx = idx_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fbpa_back.sv -----
// ============================================================================
// fbpa_back: pool state and request execution
// Holds the free stack, the busy map and the counters; carries out one
// command at a time and hands the result to the result queue.
// ============================================================================
`default_nettype none

module fbpa_back #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           restart,
  input  wire fbpa_pkg::cfg_t cfg,
  input  wire logic           cmd_empty,
  input  wire fbpa_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output fbpa_pkg::res_t      res
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int HW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = fbpa_pkg::CNT_W;
  localparam int PW = fbpa_pkg::PROD_W;
  localparam int AW = fbpa_pkg::ADDR_W;
  localparam logic [HW-1:0] EMPTY = HW'(MAX_BLOCKS);

  fbpa_pkg::back_state_t state_r;
  fbpa_pkg::back_state_t state_nxt;

  logic [HW-1:0]     head_r;
  logic [CW-1:0]     fresh_r;
  logic [CW-1:0]     used_r;
  fbpa_pkg::op_t     op_r;
  logic              ok_r;
  logic [CW-1:0]     idx_r;
  logic              grant_r;
  fbpa_pkg::status_t status_r;
  logic [PW-1:0]     prod_r;

  logic [HW-1:0] link_mem [MAX_BLOCKS];
  logic          busy_mem [MAX_BLOCKS];
  logic [HW-1:0] link_rd_r;
  logic          busy_rd_r;

  logic          in_look;
  logic          from_stack;
  logic          from_fresh;
  logic          look_grant;
  logic          rel_ok;
  logic [CW-1:0] gidx;
  logic          mem_we;
  logic          link_we;
  logic [IW-1:0] mem_addr;

  assign in_look    = (state_r == fbpa_pkg::B_LOOK);
  assign from_stack = (head_r != EMPTY);
  assign from_fresh = !from_stack && (fresh_r < cfg.total);
  assign look_grant = (op_r == fbpa_pkg::OP_GET) && (from_stack || from_fresh);
  // a busy bit counts only below the fresh mark; above it nothing was written
  assign rel_ok     = (op_r == fbpa_pkg::OP_RELEASE) && ok_r && (idx_r < fresh_r) && busy_rd_r;
  assign gidx       = from_stack ? CW'(head_r) : fresh_r;

  assign mem_we   = in_look && (look_grant || rel_ok);
  assign link_we  = in_look && rel_ok;
  assign mem_addr = IW'(look_grant ? gidx : idx_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      busy_mem[mem_addr] <= look_grant;
    end
    if (link_we) begin
      link_mem[mem_addr] <= head_r;
    end
    busy_rd_r <= busy_mem[IW'(cmd.idx)];
    link_rd_r <= link_mem[IW'(head_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbpa_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      fbpa_pkg::B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          state_nxt = fbpa_pkg::B_LOOK;
        end
      end
      fbpa_pkg::B_LOOK: begin
        state_nxt = look_grant ? fbpa_pkg::B_MUL : fbpa_pkg::B_PUSH;
      end
      fbpa_pkg::B_MUL: begin
        state_nxt = fbpa_pkg::B_PUSH;
      end
      fbpa_pkg::B_PUSH: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = fbpa_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = fbpa_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      head_r  <= EMPTY;
      fresh_r <= '0;
      used_r  <= '0;
    end else if (in_look) begin
      if (look_grant) begin
        used_r <= used_r + CW'(1);
        if (from_stack) begin
          head_r <= link_rd_r;
        end else begin
          fresh_r <= fresh_r + CW'(1);
        end
      end else if (rel_ok) begin
        head_r <= HW'(idx_r);
        if (used_r != '0) begin
          used_r <= used_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op_r  <= cmd.op;
      ok_r  <= cmd.ok;
      idx_r <= cmd.idx;
    end else if (in_look) begin
      idx_r   <= gidx;
      grant_r <= look_grant;
      if (look_grant || rel_ok) begin
        status_r <= fbpa_pkg::ST_OK;
      end else if (op_r == fbpa_pkg::OP_GET) begin
        status_r <= fbpa_pkg::ST_NO_MEMORY;
      end else begin
        status_r <= fbpa_pkg::ST_NOT_A_BLOCK;
      end
    end
    if (state_r == fbpa_pkg::B_MUL) begin
      prod_r <= PW'(idx_r) * PW'(cfg.size);
    end
  end

  assign res.status  = status_r;
  assign res.granted = grant_r ? cfg.base + AW'(prod_r) : '0;
  assign res.used    = used_r;
  assign res.free    = (cfg.total > used_r) ? cfg.total - used_r : '0;

  a_used_le_fresh : assert property (
    @(posedge clk) disable iff (!rst_n) used_r <= fresh_r
  ) else $error("allocated count exceeds handed-out blocks");

  a_head_below_fresh : assert property (
    @(posedge clk) disable iff (!rst_n) (head_r == EMPTY) || (HW'(fresh_r) > head_r)
  ) else $error("free stack top names a block never handed out");

  a_mul_after_grant : assert property (
    @(posedge clk) disable iff (!rst_n)
      (state_r == fbpa_pkg::B_MUL) |-> (grant_r && status_r == fbpa_pkg::ST_OK)
  ) else $error("address computed for a request that was not granted");

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// ============================================================================
// fixed_block_pool_allocator: one pool of fixed-size blocks with a free stack
// Get: the front hands the command straight on; the back end pops the command,
//   looks up the free stack, forms the address and pushes the result.
// Release: the front runs the 32-step divider before it queues the command.
// Reset: synchronous, active low; registers take their reset values, the
//   pool restarts empty. No clearing pass: busy bits are qualified by count.
// ============================================================================
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS  = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int ALIGN_MASK  = fbpa_pkg::ALIGN_MASK_DEF,
  parameter int QUEUE_DEPTH = fbpa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request channel
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic                           in_operation,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]    in_release_address,
  // result channel
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [1:0]                          out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]         out_granted_address,
  output logic [fbpa_pkg::CNT_W-1:0]          out_used_blocks,
  output logic [fbpa_pkg::CNT_W-1:0]          out_free_blocks,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [fbpa_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);

  localparam int AW = fbpa_pkg::ADDR_W;
  localparam int BW = fbpa_pkg::BYTES_W;
  localparam int CW = fbpa_pkg::CNT_W;
  localparam int SW = fbpa_pkg::SIZE_W;

  logic [AW-1:0] pool_base_r;
  logic [BW-1:0] block_bytes_r;
  logic [CW-1:0] block_total_r;
  logic          restart;
  logic [SW-1:0] size;
  logic [CW-1:0] total_clip;
  fbpa_pkg::cfg_t cfg;

  fbpa_pkg::cmd_t cmd_in;
  fbpa_pkg::cmd_t cmd_out;
  logic           cmd_push;
  logic           cmd_pop;
  logic           cmd_full;
  logic           cmd_empty;

  fbpa_pkg::res_t res_in;
  fbpa_pkg::res_t res_out;
  logic           res_push;
  logic           res_full;

  // --------------------------------------------------------------------------
  // Configuration registers. Any write to a known register restarts the
  // pool: drop the free stack and clear the counters. Unknown indexes do
  // nothing at all.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= fbpa_pkg::RST_POOL_BASE;
      block_bytes_r <= fbpa_pkg::RST_BLOCK_BYTES;
      block_total_r <= fbpa_pkg::RST_BLOCK_TOTAL;
    end else if (cfg_we) begin
      case (cfg_index)
        fbpa_pkg::REG_POOL_BASE:   pool_base_r   <= cfg_data;
        fbpa_pkg::REG_BLOCK_BYTES: block_bytes_r <= cfg_data[BW-1:0];
        fbpa_pkg::REG_BLOCK_TOTAL: block_total_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index inside {fbpa_pkg::REG_POOL_BASE,
                                                fbpa_pkg::REG_BLOCK_BYTES,
                                                fbpa_pkg::REG_BLOCK_TOTAL});

  // Round the block size up to the alignment; clip the count to capacity.
  // A zero size leaves a pool with no blocks.
  assign size       = (SW'(block_bytes_r) + SW'(ALIGN_MASK)) & ~SW'(ALIGN_MASK);
  assign total_clip = (32'(block_total_r) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                              : block_total_r;

  assign cfg.base  = pool_base_r;
  assign cfg.size  = size;
  assign cfg.total = (size == '0) ? '0 : total_clip;

  // --------------------------------------------------------------------------
  // Front: take the request transfer, classify it and, for a release, divide
  // the offset by the block size. Hold the next request until the command
  // has been queued.
  // --------------------------------------------------------------------------
  fbpa_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_operation       (in_operation),
    .in_release_address (in_release_address),
    .cfg                (cfg),
    .cmd_push           (cmd_push),
    .cmd                (cmd_in),
    .cmd_full           (cmd_full)
  );

  // Command queue: lets the divider start on the next release while the back
  // end still waits on a full result queue.
  fbpa_fifo #(
    .T     (fbpa_pkg::cmd_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  // --------------------------------------------------------------------------
  // Back: pop the free stack or advance the fresh mark on a get, check the
  // busy bit and push the block on a release, then form the result.
  // --------------------------------------------------------------------------
  fbpa_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue: its head drives the result ports while not empty.
  fbpa_fifo #(
    .T     (fbpa_pkg::res_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_status          = res_out.status;
  assign out_granted_address = res_out.granted;
  assign out_used_blocks     = res_out.used;
  assign out_free_blocks     = res_out.free;

endmodule

`default_nettype wire
